// ===== hdl/wtosc_pkg.sv =====
// Shared types and constants for the wavetable oscillator.
package wtosc_pkg;

   // field widths fixed by the interface
   localparam int REQ_TYPE_W = 2;
   localparam int FREQ_W     = 24;
   localparam int INDEX_W    = 10;
   localparam int SAMPLE_W   = 16;
   localparam int PHASE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // increment = floor(freq * phase_per_hz / 2^16)
   localparam int INC_SHIFT = 16;

   // output queue depth; also the number of ticks allowed in flight
   localparam int OUT_DEPTH = 8;

   typedef logic [REQ_TYPE_W-1:0]      req_code_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [PHASE_W-1:0]         phase_type;

   // request codes
   localparam req_code_type REQ_TICK    = 2'd0;
   localparam req_code_type REQ_WRITE   = 2'd1;
   localparam req_code_type REQ_RESTART = 2'd2;

   // register indexes
   localparam csr_idx_type CSR_PHASE_PER_HZ = 2'd0;
   localparam csr_idx_type CSR_START_PHASE  = 2'd1;
   localparam csr_idx_type CSR_INTERPOLATE  = 2'd2;

   // register reset values
   localparam phase_type RST_PHASE_PER_HZ = 32'd22906492;
   localparam phase_type RST_START_PHASE  = 32'd0;
   localparam logic      RST_INTERPOLATE  = 1'b1;

endpackage

// ===== hdl/wavetable_oscillator.sv =====
// Wavetable oscillator top level: phase accumulator, banked table, interpolator.
// An accepted tick passes the stage 1 (table read), stage 2 and stage 3 registers
// and the output queue before its sample shows on rsp_; throughput is one word per
// cycle while credit remains, set by the phase add and the even/odd table banks.
// Synchronous reset clears phase, pipeline and output queue and reloads registers;
// the table keeps its contents and holds garbage until written.
module wavetable_oscillator #(
   parameter int TABLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wtosc_pkg::req_code_type       req_type,
   input  logic signed [23:0]            req_freq,
   input  logic [9:0]                    req_entry_index,
   input  logic signed [15:0]            req_entry_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_sample,
   // register write port
   input  logic                          csr_write_en,
   input  wtosc_pkg::csr_idx_type        csr_index,
   input  logic [31:0]                   csr_wdata
);
   import wtosc_pkg::*;

   localparam int FRAC_W     = PHASE_W - TABLE_BITS;
   localparam int BANK_BITS  = TABLE_BITS - 1;
   localparam int BANK_DEPTH = 1 << BANK_BITS;
   localparam int INC_PROD_W = FREQ_W + PHASE_W + 1;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int IPROD_W    = DIFF_W + FRAC_W + 1;
   localparam int SUM_W      = SAMPLE_W + 2;
   localparam int PTR_W      = $clog2(OUT_DEPTH);
   localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

   // ---------------- configuration registers ----------------
   phase_type pph_ff, start_ff;
   logic      interp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pph_ff    <= RST_PHASE_PER_HZ;
         start_ff  <= RST_START_PHASE;
         interp_ff <= RST_INTERPOLATE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PHASE_PER_HZ: pph_ff    <= csr_wdata;
            CSR_START_PHASE:  start_ff  <= csr_wdata;
            CSR_INTERPOLATE:  interp_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- request decode ----------------
   logic req_acc, tick_acc, write_acc, restart_acc;
   logic [CNT_W-1:0] credit_ff, credit_in;

   assign req_stall   = (credit_ff == CNT_W'(OUT_DEPTH));
   assign req_acc     = req_valid && !req_stall;
   assign tick_acc    = req_acc && (req_type == REQ_TICK);
   assign write_acc   = req_acc && (req_type == REQ_WRITE);
   assign restart_acc = req_acc && (req_type == REQ_RESTART);

   // ---------------- phase accumulator ----------------
   // phase_ff lags by the increment of the last tick, which sits in inc_ff
   phase_type phase_ff, phase_in, phase_cur;
   phase_type inc_ff, inc_in;
   logic signed [INC_PROD_W-1:0] inc_prod;

   assign inc_prod  = req_freq * $signed({1'b0, pph_ff});
   assign inc_in    = tick_acc ? inc_prod[INC_SHIFT+PHASE_W-1:INC_SHIFT] : '0;
   assign phase_cur = phase_ff + inc_ff;
   assign phase_in  = restart_acc ? start_ff : phase_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         inc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         inc_ff   <= inc_in;
      end
   end

   // ---------------- banked table ----------------
   // even entries in one bank, odd in the other, so idx and idx+1 read together
   logic [TABLE_BITS-1:0] rd_idx, wr_idx;
   logic [BANK_BITS-1:0]  even_addr, odd_addr;
   logic [SAMPLE_W-1:0]   even_mem [BANK_DEPTH];
   logic [SAMPLE_W-1:0]   odd_mem  [BANK_DEPTH];
   logic [SAMPLE_W-1:0]   even_rd_ff, odd_rd_ff;

   assign rd_idx    = phase_cur[PHASE_W-1 -: TABLE_BITS];
   assign wr_idx    = TABLE_BITS'(req_entry_index);
   assign odd_addr  = rd_idx[TABLE_BITS-1:1];
   assign even_addr = rd_idx[TABLE_BITS-1:1] + BANK_BITS'(rd_idx[0]);

   always_ff @(posedge clock) begin
      if (write_acc && !wr_idx[0])
         even_mem[wr_idx[TABLE_BITS-1:1]] <= req_entry_value;
      if (tick_acc)
         even_rd_ff <= even_mem[even_addr];
   end

   always_ff @(posedge clock) begin
      if (write_acc && wr_idx[0])
         odd_mem[wr_idx[TABLE_BITS-1:1]] <= req_entry_value;
      if (tick_acc)
         odd_rd_ff <= odd_mem[odd_addr];
   end

   // ---------------- stage 1: table words read ----------------
   logic              s1_valid_ff, s1_sel_ff, s1_interp_ff;
   logic [FRAC_W-1:0] s1_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= tick_acc;
   end

   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_sel_ff    <= rd_idx[0];
         s1_interp_ff <= interp_ff;
         s1_frac_ff   <= phase_cur[FRAC_W-1:0];
      end
   end

   // ---------------- stage 2: pick neighbors, take difference ----------------
   sample_type              s1_a, s1_b;
   logic signed [DIFF_W-1:0] s1_diff;
   logic                     s2_valid_ff, s2_interp_ff;
   sample_type               s2_a_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff;
   logic [FRAC_W-1:0]        s2_frac_ff;

   assign s1_a    = s1_sel_ff ? odd_rd_ff : even_rd_ff;
   assign s1_b    = s1_sel_ff ? even_rd_ff : odd_rd_ff;
   assign s1_diff = DIFF_W'(s1_b) - DIFF_W'(s1_a);

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_a_ff      <= s1_a;
         s2_diff_ff   <= s1_diff;
         s2_frac_ff   <= s1_frac_ff;
         s2_interp_ff <= s1_interp_ff;
      end
   end

   // ---------------- stage 3: difference times fraction ----------------
   logic signed [IPROD_W-1:0] s2_prod;
   logic                      s3_valid_ff, s3_interp_ff;
   sample_type                s3_a_ff;
   logic signed [IPROD_W-1:0] s3_prod_ff;

   assign s2_prod = s2_diff_ff * $signed({1'b0, s2_frac_ff});

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_a_ff      <= s2_a_ff;
         s3_prod_ff   <= s2_prod;
         s3_interp_ff <= s2_interp_ff;
      end
   end

   // ---------------- final add and saturate ----------------
   logic signed [SUM_W-1:0] s3_sum;
   sample_type              s3_sample;

   // arithmetic shift of the product floors toward minus infinity
   assign s3_sum = SUM_W'(s3_a_ff) + s3_prod_ff[IPROD_W-1:FRAC_W];

   always_comb begin
      if (!s3_interp_ff)
         s3_sample = s3_a_ff;
      else if (s3_sum > SUM_W'(32767))
         s3_sample = 16'sh7FFF;
      else if (s3_sum < -SUM_W'(32768))
         s3_sample = 16'sh8000;
      else
         s3_sample = s3_sum[SAMPLE_W-1:0];
   end

   // ---------------- output queue ----------------
   // credits cover every tick in flight, so the queue never overflows
   logic [SAMPLE_W-1:0] out_mem [OUT_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic                rsp_pop;

   assign rsp_valid  = (fill_ff != '0);
   assign rsp_sample = out_mem[rd_ptr_ff];
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign credit_in  = credit_ff + CNT_W'(tick_acc) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (s3_valid_ff)
         out_mem[wr_ptr_ff] <= s3_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (s3_valid_ff)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (rsp_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         fill_ff   <= fill_ff + CNT_W'(s3_valid_ff) - CNT_W'(rsp_pop);
         credit_ff <= credit_in;
      end
   end

   // ---------------- assertions ----------------
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(OUT_DEPTH))
      else $error("tick credit count above queue depth");

   a_fill_le_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("queue holds more words than ticks in flight");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (fill_ff < CNT_W'(OUT_DEPTH)) || rsp_pop)
      else $error("output queue overflow");

   a_restart_phase: assert property (@(posedge clock) disable iff (reset)
      restart_acc |=> (phase_ff == $past(start_ff)) && (inc_ff == '0))
      else $error("restart did not load start phase");

   a_tick_enters: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> s1_valid_ff ##2 s3_valid_ff)
      else $error("tick lost in pipeline");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the wavetable oscillator: table load, ticks, restarts, registers.
module testbench;
   import wtosc_pkg::*;

   localparam int TBL_BITS    = 10;
   localparam int TBL_SIZE    = 1 << TBL_BITS;
   localparam int FRAC_W      = PHASE_W - TBL_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   // codes outside the defined set, used as noise
   localparam req_code_type REQ_UNKNOWN = 2'd3;
   localparam csr_idx_type  CSR_UNUSED  = 2'd3;

   localparam logic signed [23:0] FREQ_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] FREQ_MIN = 24'sh800000;

   // one request word
   typedef struct {
      req_code_type       kind;
      logic signed [23:0] freq;
      logic [9:0]         index;
      logic signed [15:0] value;
   } osc_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_code_type        req_type = REQ_TICK;
   logic signed [23:0]  req_freq = '0;
   logic [9:0]          req_entry_index = '0;
   logic signed [15:0]  req_entry_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [15:0]  rsp_sample;
   logic                csr_write_en = 1'b0;
   csr_idx_type         csr_index = CSR_PHASE_PER_HZ;
   logic [31:0]         csr_wdata = '0;

   // shadow of the oscillator state and registers
   logic signed [15:0]  wave_mem [0:TBL_SIZE-1];
   phase_type           osc_phase = '0;
   phase_type           cfg_phase_per_hz = RST_PHASE_PER_HZ;
   phase_type           cfg_start_phase = RST_START_PHASE;
   logic                cfg_interpolate = RST_INTERPOLATE;

   osc_word_type        pending_words[$];
   sample_type          expected_samples[$];
   osc_word_type        offered;
   sample_type          want_sample;

   int                  req_gap = 0;
   int                  rsp_gap = 0;
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   bit                  pressure_req = 1'b0;
   bit                  pressure_done = 1'b0;
   int                  hold_left = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;

   wavetable_oscillator #(.TABLE_BITS(TBL_BITS)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_freq        (req_freq),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // apply one accepted word to the shadow state; ticks queue the sample they produce
   function automatic void advance_oscillator(osc_word_type w);
      logic [TBL_BITS-1:0] idx;
      logic [TBL_BITS-1:0] next_idx;
      longint              a;
      longint              b;
      longint              v;
      longint              inc;
      case (w.kind)
         REQ_TICK: begin
            idx = osc_phase[PHASE_W-1 -: TBL_BITS];
            next_idx = idx + TBL_BITS'(1);
            a = wave_mem[idx];
            v = a;
            if (cfg_interpolate) begin
               b = wave_mem[next_idx];
               // floor of the weighted difference, then saturate
               v = a + (((b - a) * longint'(osc_phase[FRAC_W-1:0])) >>> FRAC_W);
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
            end
            expected_samples.push_back(v[15:0]);
            inc = (longint'(w.freq) * longint'(cfg_phase_per_hz)) >>> INC_SHIFT;
            osc_phase = osc_phase + inc[31:0];
         end
         REQ_WRITE: wave_mem[w.index[TBL_BITS-1:0]] = w.value;
         REQ_RESTART: osc_phase = cfg_start_phase;
         default: ;
      endcase
   endfunction

   function automatic void queue_word(req_code_type k, logic signed [23:0] f,
                                      logic [9:0] ix, logic signed [15:0] v);
      osc_word_type w;
      w.kind = k;
      w.freq = f;
      w.index = ix;
      w.value = v;
      pending_words.push_back(w);
   endfunction

   // random word; returns 0 for words the block ignores
   function automatic bit queue_random_word();
      int                 pick;
      logic signed [23:0] f;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: f = $urandom_range(0, 1) ? FREQ_MAX : FREQ_MIN;
         1: f = 24'($urandom_range(0, 8192)) - 24'sd4096;
         default: f = 24'($urandom);
      endcase
      if (pick < 70) queue_word(REQ_TICK, f, 10'($urandom), 16'($urandom));
      else if (pick < 84) queue_word(REQ_WRITE, f, 10'($urandom), 16'($urandom));
      else if (pick < 92) queue_word(REQ_RESTART, f, 10'($urandom), 16'($urandom));
      else queue_word(REQ_UNKNOWN, f, 10'($urandom), 16'($urandom));
      return pick < 92;
   endfunction

   // register write, mirrored into the shadow copy; only called while idle
   task automatic write_reg(csr_idx_type idx, logic [31:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_PHASE_PER_HZ: cfg_phase_per_hz = data;
         CSR_START_PHASE: cfg_start_phase = data;
         CSR_INTERPOLATE: cfg_interpolate = data[0];
         default: ;
      endcase
   endtask

   // all words sent, all samples back, then let writes and restarts drain
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_oscillator(offered);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               offered = pending_words.pop_front();
               req_type <= offered.kind;
               req_freq <= offered.freq;
               req_entry_index <= offered.index;
               req_entry_value <= offered.value;
               req_valid <= 1'b1;
               req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // sample monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample %0d, none expected", $time, rsp_sample);
               error_count++;
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_sample !== want_sample) begin
                  $display("%0t: sample mismatch, expected %0d, got %0d",
                           $time, want_sample, rsp_sample);
                  error_count++;
               end
            end
            rsp_gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
         end
         // long hold-off so the block fills up and stalls its input
         if (pressure_req && !pressure_done) begin
            hold_left = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wavetable_oscillator test failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      int counted;
      logic signed [15:0] v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole table first so no tick reads an unwritten entry;
      // extremes placed where interpolation spans the wrap and full range
      for (int i = 0; i < TBL_SIZE; i++) begin
         if (i == 0) v = 16'sh7FFF;
         else if (i == 1 || i == TBL_SIZE - 1) v = 16'sh8000;
         else v = 16'($urandom);
         queue_word(REQ_WRITE, 24'($urandom), 10'(i), v);
      end

      // reset register values
      queue_word(REQ_RESTART, '0, '0, '0);
      queue_word(REQ_TICK, '0, '1, '1);
      queue_word(REQ_TICK, '0, '0, '0);
      queue_word(REQ_TICK, FREQ_MAX, '0, '0);
      queue_word(REQ_TICK, FREQ_MIN, '0, '0);
      queue_word(REQ_UNKNOWN, 24'($urandom), 10'($urandom), 16'($urandom));
      queue_word(REQ_TICK, 24'sd1, '0, '0);
      queue_word(REQ_TICK, -24'sd1, '0, '0);
      wait_idle();

      // largest scale and a start phase just below the wrap (last entry to entry 0)
      write_reg(CSR_PHASE_PER_HZ, 32'hFFFF_FFFF);
      write_reg(CSR_START_PHASE, 32'hFFFF_FFFF);
      write_reg(CSR_INTERPOLATE, 32'd1);
      write_reg(CSR_UNUSED, 32'($urandom));
      @(negedge clock);
      queue_word(REQ_RESTART, '0, '0, '0);
      queue_word(REQ_TICK, 24'sd1, '0, '0);
      queue_word(REQ_TICK, -24'sd1, '0, '0);
      queue_word(REQ_TICK, FREQ_MAX, '0, '0);
      queue_word(REQ_TICK, FREQ_MIN, '0, '0);
      queue_word(REQ_TICK, '0, '0, '0);
      wait_idle();

      // zero scale freezes the phase; truncating lookup
      write_reg(CSR_PHASE_PER_HZ, 32'd0);
      write_reg(CSR_START_PHASE, $urandom);
      write_reg(CSR_INTERPOLATE, 32'd0);
      @(negedge clock);
      queue_word(REQ_RESTART, '0, '0, '0);
      repeat (3) queue_word(REQ_TICK, 24'($urandom), '0, '0);
      queue_word(REQ_UNKNOWN, 24'($urandom), 10'($urandom), 16'($urandom));
      wait_idle();

      // random phases with varying registers and idling patterns
      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(0, 3))
            0: write_reg(CSR_PHASE_PER_HZ, $urandom);
            1: write_reg(CSR_PHASE_PER_HZ, $urandom_range(0, 65536));
            2: write_reg(CSR_PHASE_PER_HZ, RST_PHASE_PER_HZ);
            default: write_reg(CSR_PHASE_PER_HZ, 32'hFFFF_FFFF);
         endcase
         write_reg(CSR_START_PHASE, $urandom);
         write_reg(CSR_INTERPOLATE, $urandom_range(0, 1));
         if (p == 4) write_reg(CSR_UNUSED, $urandom);
         @(negedge clock);
         req_idle_on = p[0];
         rsp_idle_on = p[1];
         pressure_req = (p == 2);
         counted = 0;
         while (counted < 100) counted += queue_random_word();
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (error_count == 0) $display("wavetable_oscillator test passed");
      else $display("wavetable_oscillator test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/wtosc_pkg.sv
hdl/wavetable_oscillator.sv
bench/testbench.sv
